### hdl/igfa_pkg.sv
package igfa_pkg;

  localparam int PASSES     = 15;
  localparam int MAX_HEIGHT = 256;
  localparam int MAX_WIDTH  = 1024;

  // slot history per stage: one column plus two slots
  localparam int HIST  = MAX_HEIGHT + 2;
  localparam int PTR_W = $clog2(HIST);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int H_W   = $clog2(MAX_HEIGHT + 1);
  localparam int W_W   = $clog2(MAX_WIDTH + 1);

  localparam int PIX_W          = 24;
  localparam int IMAGE_WIDTH_W  = 11;
  localparam int IMAGE_HEIGHT_W = 9;
  localparam int CFG_DATA_W     = 24;
  localparam int CFG_INDEX_W    = 2;

  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_GAP_COLOR    = 2'd2;

  localparam logic [IMAGE_WIDTH_W-1:0]  RESET_IMAGE_WIDTH  = 11'd256;
  localparam logic [IMAGE_HEIGHT_W-1:0] RESET_IMAGE_HEIGHT = 9'd256;
  localparam logic [PIX_W-1:0]          RESET_GAP_COLOR    = 24'hCDCDCD;

  typedef logic [PIX_W-1:0] pixel_t;

  // one slot travelling down the chain of pass stages
  typedef struct packed {
    logic             present;
    logic             valid;
    pixel_t           pixel;
    logic [PTR_W-1:0] ptr;
    logic [H_W-1:0]   fill;
    logic             last;
  } token_t;

endpackage

### hdl/igfa_ram.sv
module igfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hdl/igfa_cell.sv
module igfa_cell (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic [igfa_pkg::H_W-1:0] eff_h,
  input  logic [igfa_pkg::W_W-1:0] eff_w,
  input  igfa_pkg::pixel_t        gap_color,
  input  igfa_pkg::token_t        tok_in,
  output igfa_pkg::token_t        tok_out
);

  import igfa_pkg::*;

  // received history entry: pixel of a slot, pixel and valid of the slot before
  typedef struct packed {
    pixel_t cur;
    pixel_t prev;
    logic   prev_valid;
  } in_entry_t;

  // updated history entry: result of a slot and of the two slots before
  typedef struct packed {
    pixel_t y0;
    pixel_t y1;
    pixel_t y2;
  } up_entry_t;

  typedef struct packed {
    token_t           tok;
    logic [PTR_W-1:0] c_addr;
    logic             warm;
  } stage_t;

  function automatic logic [PTR_W-1:0] back_mod(logic [PTR_W-1:0] p, logic [H_W-1:0] k);
    logic [PTR_W:0] s;
    s = (PTR_W+1)'(p) + (PTR_W+1)'(HIST) - (PTR_W+1)'(k);
    if (s >= (PTR_W+1)'(HIST)) begin
      s = s - (PTR_W+1)'(HIST);
    end
    return s[PTR_W-1:0];
  endfunction

  function automatic logic [7:0] avg_chan(logic [7:0] a0, logic [7:0] a1, logic [7:0] a2,
                                          logic [7:0] a3, logic [7:0] a4, logic [7:0] a5,
                                          logic [7:0] a6, logic [7:0] a7);
    logic [10:0] s;
    s = ((11'(a0) + 11'(a1)) + (11'(a2) + 11'(a3))) +
        ((11'(a4) + 11'(a5)) + (11'(a6) + 11'(a7)));
    return s[10:3];
  endfunction

  logic [PTR_W-1:0] a_in;
  logic [PTR_W-1:0] a_up;
  logic [PTR_W-1:0] a_c;
  stage_t           st;
  in_entry_t        ie;
  up_entry_t        ue;
  logic [$bits(in_entry_t)-1:0] in_rdata;
  logic [$bits(up_entry_t)-1:0] up_rdata;

  pixel_t           x1;
  pixel_t           x2;
  logic             v1;
  pixel_t           y1;
  pixel_t           y2;
  logic [ROW_W-1:0] row;
  logic [COL_W-1:0] col;

  logic             we;
  logic             cv;
  logic             interior;
  logic             row_end;
  logic             col_end;
  pixel_t           xc;
  pixel_t           res;
  pixel_t           nb [8];
  pixel_t           avg;
  in_entry_t        in_wdata;
  up_entry_t        up_wdata;

  // read addresses for the slot entering the stage
  always_comb begin
    a_in = back_mod(tok_in.ptr, eff_h);
    a_up = back_mod(a_in, eff_h);
    a_c  = back_mod(a_in, H_W'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.tok.present <= 1'b0;
    end else if (en) begin
      st.tok    <= tok_in;
      st.c_addr <= a_c;
      st.warm   <= (tok_in.fill >= eff_h);
    end
  end

  igfa_ram #(
    .WIDTH ($bits(in_entry_t)),
    .DEPTH (HIST)
  ) u_in_ram (
    .clk   (clk),
    .we    (we),
    .waddr (st.tok.ptr),
    .wdata (in_wdata),
    .re    (en),
    .raddr (a_in),
    .rdata (in_rdata)
  );

  igfa_ram #(
    .WIDTH ($bits(up_entry_t)),
    .DEPTH (HIST)
  ) u_up_ram (
    .clk   (clk),
    .we    (we),
    .waddr (st.c_addr),
    .wdata (up_wdata),
    .re    (en),
    .raddr (a_up),
    .rdata (up_rdata)
  );

  assign ie = in_rdata;
  assign ue = up_rdata;

  always_comb begin
    we       = en & st.tok.present;
    xc       = ie.prev;
    cv       = st.tok.present & st.warm & ie.prev_valid;
    interior = (row != '0) && ((H_W+1)'(row) + (H_W+1)'(2) <= (H_W+1)'(eff_h)) &&
               (col != '0) && ((W_W+1)'(col) + (W_W+1)'(2) <= (W_W+1)'(eff_w)) &&
               (xc == gap_color);
    nb[0] = ue.y2;
    nb[1] = ue.y1;
    nb[2] = ue.y0;
    nb[3] = y1;
    nb[4] = ie.cur;
    nb[5] = x2;
    nb[6] = x1;
    nb[7] = st.tok.pixel;
    avg = {avg_chan(nb[0][23:16], nb[1][23:16], nb[2][23:16], nb[3][23:16],
                    nb[4][23:16], nb[5][23:16], nb[6][23:16], nb[7][23:16]),
           avg_chan(nb[0][15:8], nb[1][15:8], nb[2][15:8], nb[3][15:8],
                    nb[4][15:8], nb[5][15:8], nb[6][15:8], nb[7][15:8]),
           avg_chan(nb[0][7:0], nb[1][7:0], nb[2][7:0], nb[3][7:0],
                    nb[4][7:0], nb[5][7:0], nb[6][7:0], nb[7][7:0])};
    if (!cv) begin
      res = '0;
    end else if (interior) begin
      res = avg;
    end else begin
      res = xc;
    end
    row_end = ((H_W+1)'(row) + (H_W+1)'(1) >= (H_W+1)'(eff_h));
    col_end = ((W_W+1)'(col) + (W_W+1)'(1) >= (W_W+1)'(eff_w));
    in_wdata.cur        = st.tok.pixel;
    in_wdata.prev       = x1;
    in_wdata.prev_valid = v1;
    up_wdata.y0         = res;
    up_wdata.y1         = y1;
    up_wdata.y2         = y2;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      x2 <= x1;
      x1 <= st.tok.pixel;
      y2 <= y1;
      y1 <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1  <= 1'b0;
      row <= '0;
      col <= '0;
    end else if (we) begin
      v1 <= st.tok.valid;
      if (cv) begin
        if (row_end) begin
          row <= '0;
          col <= col_end ? '0 : col + COL_W'(1);
        end else begin
          row <= row + ROW_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.present <= 1'b0;
    end else if (en) begin
      tok_out.present <= st.tok.present;
      tok_out.valid   <= cv;
      tok_out.pixel   <= res;
      tok_out.ptr     <= st.tok.ptr;
      tok_out.fill    <= st.tok.fill;
      tok_out.last    <= cv & (((H_W+1)'(row) + (H_W+1)'(1)) == (H_W+1)'(eff_h)) &
                         (((W_W+1)'(col) + (W_W+1)'(1)) == (W_W+1)'(eff_w));
    end
  end

endmodule

### hdl/iterative_gap_fill_average_core.sv
// channel   direction  handshake            word
// in        input      in_valid/in_ready    pixel_in, flush
// out       output     out_valid/out_ready  pixel_out, frame_last
// cfg       input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// one word per cycle unless a held result stalls the chain; each pass stage is two
// register stages, which a slot passes in turn before reaching the output register
// a pixel's result leaves after PASSES*(height+1) further words; flush words drain
// rst is synchronous; no clearing pass, the history rams need none
// a result held in the output register freezes the whole chain and drops in_ready
module iterative_gap_fill_average_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  igfa_pkg::pixel_t                    pixel_in,
  input  logic                                flush,
  output logic                                out_valid,
  input  logic                                out_ready,
  output igfa_pkg::pixel_t                    pixel_out,
  output logic                                frame_last,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [igfa_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [igfa_pkg::CFG_DATA_W-1:0]     cfg_data
);

  import igfa_pkg::*;

  localparam int HC_W = (IMAGE_HEIGHT_W > H_W) ? IMAGE_HEIGHT_W + 1 : H_W + 1;
  localparam int WC_W = (IMAGE_WIDTH_W > W_W) ? IMAGE_WIDTH_W + 1 : W_W + 1;

  logic [IMAGE_WIDTH_W-1:0]  image_width;
  logic [IMAGE_HEIGHT_W-1:0] image_height;
  pixel_t                    gap_color;
  logic [H_W-1:0]            eff_h;
  logic [W_W-1:0]            eff_w;
  logic [HC_W-1:0]           hx;
  logic [WC_W-1:0]           wx;
  logic                      en;
  logic [PTR_W-1:0]          slot_ptr;
  logic [H_W-1:0]            fill;
  token_t                    chain [PASSES+1];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= RESET_IMAGE_WIDTH;
      image_height <= RESET_IMAGE_HEIGHT;
      gap_color    <= RESET_GAP_COLOR;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[IMAGE_WIDTH_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data[IMAGE_HEIGHT_W-1:0];
        REG_GAP_COLOR:    gap_color    <= cfg_data[PIX_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp the frame size to at least 3 and to what the stages can hold
  always_comb begin
    hx = HC_W'(image_height);
    wx = WC_W'(image_width);
    if (hx < HC_W'(3)) begin
      hx = HC_W'(3);
    end else if (hx > HC_W'(MAX_HEIGHT)) begin
      hx = HC_W'(MAX_HEIGHT);
    end
    if (wx < WC_W'(3)) begin
      wx = WC_W'(3);
    end else if (wx > WC_W'(MAX_WIDTH)) begin
      wx = WC_W'(MAX_WIDTH);
    end
    eff_h = hx[H_W-1:0];
    eff_w = wx[W_W-1:0];
  end

  assign en       = ~out_valid | out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_ptr <= '0;
      fill     <= '0;
    end else if (in_valid && en) begin
      slot_ptr <= (slot_ptr == PTR_W'(HIST - 1)) ? '0 : slot_ptr + PTR_W'(1);
      if (fill != H_W'(MAX_HEIGHT)) begin
        fill <= fill + H_W'(1);
      end
    end
  end

  always_comb begin
    chain[0].present = in_valid;
    chain[0].valid   = ~flush;
    chain[0].pixel   = flush ? '0 : pixel_in;
    chain[0].ptr     = slot_ptr;
    chain[0].fill    = fill;
    chain[0].last    = 1'b0;
  end

  for (genvar s = 0; s < PASSES; s++) begin : g_pass
    igfa_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .eff_h     (eff_h),
      .eff_w     (eff_w),
      .gap_color (gap_color),
      .tok_in    (chain[s]),
      .tok_out   (chain[s+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= chain[PASSES].present & chain[PASSES].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pixel_out  <= chain[PASSES].pixel;
      frame_last <= chain[PASSES].last;
    end
  end

endmodule

### tb/iterative_gap_fill_average_core_tb.sv
module iterative_gap_fill_average_core_tb;
  import igfa_pkg::*;

  localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED = 2'd3;
  localparam int WORD_BUDGET = 950;
  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_CYCLES = 600;
  localparam int CHAIN_CYCLES = 2 * PASSES + 4;
  localparam int N_CASES = 23;

  typedef struct packed {
    pixel_t pix;
    logic   fl;
    logic   typed;
    pixel_t exp_pix;
    logic   exp_last;
  } fill_case_t;

  typedef struct packed {
    logic   typed;
    pixel_t pix;
    logic   last;
  } known_word_t;

  typedef struct packed {
    pixel_t pix;
    logic   last;
  } out_word_t;

  // frame 5x3 with the reset hole color, then a partial frame with a flush inside
  localparam fill_case_t FILL_CASES [N_CASES] = '{
    '{24'h000000, 1'b0, 1'b1, 24'h000000, 1'b0},
    '{24'hCDCDCD, 1'b0, 1'b1, 24'hCDCDCD, 1'b0},
    '{24'hFFFFFF, 1'b0, 1'b1, 24'hFFFFFF, 1'b0},
    '{24'hFFFFFF, 1'b0, 1'b1, 24'hFFFFFF, 1'b0},
    '{24'hCDCDCD, 1'b0, 1'b0, 24'h000000, 1'b0},
    '{24'h000000, 1'b0, 1'b1, 24'h000000, 1'b0},
    '{24'hCDCDCD, 1'b0, 1'b1, 24'hCDCDCD, 1'b0},
    '{24'hCDCDCC, 1'b0, 1'b1, 24'hCDCDCC, 1'b0},
    '{24'hCDCDCD, 1'b0, 1'b1, 24'hCDCDCD, 1'b0},
    '{24'h808080, 1'b0, 1'b1, 24'h808080, 1'b0},
    '{24'hCDCDCD, 1'b0, 1'b0, 24'h000000, 1'b0},
    '{24'h7F7F7F, 1'b0, 1'b1, 24'h7F7F7F, 1'b0},
    '{24'hFFFFFF, 1'b0, 1'b1, 24'hFFFFFF, 1'b0},
    '{24'hCDCDCD, 1'b0, 1'b1, 24'hCDCDCD, 1'b0},
    '{24'h010203, 1'b0, 1'b1, 24'h010203, 1'b1},
    '{24'h123456, 1'b0, 1'b1, 24'h123456, 1'b0},
    '{24'hFEDCBA, 1'b0, 1'b1, 24'hFEDCBA, 1'b0},
    '{24'hFFFFFF, 1'b1, 1'b0, 24'h000000, 1'b0},
    '{24'h000001, 1'b0, 1'b1, 24'h000001, 1'b0},
    '{24'hFFFFFF, 1'b0, 1'b1, 24'hFFFFFF, 1'b0},
    '{24'hCDCDCD, 1'b0, 1'b0, 24'h000000, 1'b0},
    '{24'hFFFFFF, 1'b0, 1'b1, 24'hFFFFFF, 1'b0},
    '{24'h00FF00, 1'b0, 1'b1, 24'h00FF00, 1'b0}
  };

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  pixel_t pixel_in;
  logic flush;
  logic out_valid;
  logic out_ready;
  pixel_t pixel_out;
  logic frame_last;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  iterative_gap_fill_average_core dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .pixel_in   (pixel_in),
    .flush      (flush),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .pixel_out  (pixel_out),
    .frame_last (frame_last),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // fill chain state
  logic [IMAGE_WIDTH_W-1:0] cols_reg;
  logic [IMAGE_HEIGHT_W-1:0] rows_reg;
  pixel_t hole_color;
  pixel_t arrived_pix [PASSES][HIST];
  logic arrived_ok [PASSES][HIST];
  pixel_t filled_pix [PASSES][HIST];
  int row_at [PASSES];
  int col_at [PASSES];
  int slot_wr;
  int slot_count;

  known_word_t known_q [$];
  out_word_t filled_q [$];
  int mismatches = 0;
  int seen = 0;
  int send_calm = 0;
  int words_sent = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int eff_height();
    int h;
    h = int'(rows_reg);
    if (h < 3) h = 3;
    if (h > MAX_HEIGHT) h = MAX_HEIGHT;
    return h;
  endfunction

  function automatic int eff_width();
    int w;
    w = int'(cols_reg);
    if (w < 3) w = 3;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    return w;
  endfunction

  function automatic int back_slot(input int from, input int k);
    return (from + HIST - k) % HIST;
  endfunction

  function automatic pixel_t mean_of_eight(input pixel_t nb [8]);
    logic [10:0] r, g, b;
    r = '0;
    g = '0;
    b = '0;
    for (int i = 0; i < 8; i++) begin
      r = r + 11'(nb[i][23:16]);
      g = g + 11'(nb[i][15:8]);
      b = b + 11'(nb[i][7:0]);
    end
    return {r[10:3], g[10:3], b[10:3]};
  endfunction

  task automatic fill_chain_reset();
    cols_reg = RESET_IMAGE_WIDTH;
    rows_reg = RESET_IMAGE_HEIGHT;
    hole_color = RESET_GAP_COLOR;
    for (int s = 0; s < PASSES; s++) begin
      for (int i = 0; i < HIST; i++) begin
        arrived_pix[s][i] = '0;
        arrived_ok[s][i] = 1'b0;
        filled_pix[s][i] = '0;
      end
      row_at[s] = 0;
      col_at[s] = 0;
    end
    slot_wr = 0;
    slot_count = 0;
  endtask

  task automatic fill_cfg_write(input logic [CFG_INDEX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_IMAGE_WIDTH: cols_reg = data[IMAGE_WIDTH_W-1:0];
      REG_IMAGE_HEIGHT: rows_reg = data[IMAGE_HEIGHT_W-1:0];
      REG_GAP_COLOR: hole_color = data[PIX_W-1:0];
      default: ;
    endcase
  endtask

  task automatic fill_chain_step(input pixel_t pix, input logic fl, output logic got,
                                 output pixel_t res_pix, output logic res_last);
    int h, w, wp, c, row, col;
    logic v, cv, lst;
    pixel_t p, cp, res;
    pixel_t nb [8];
    h = eff_height();
    w = eff_width();
    v = !fl;
    p = fl ? '0 : pix;
    wp = slot_wr;
    lst = 1'b0;
    for (int s = 0; s < PASSES; s++) begin
      c = back_slot(wp, h + 1);
      arrived_pix[s][wp] = p;
      arrived_ok[s][wp] = v;
      cv = arrived_ok[s][c];
      cp = arrived_pix[s][c];
      res = '0;
      if (cv) begin
        row = row_at[s];
        col = col_at[s];
        res = cp;
        if (row >= 1 && row + 2 <= h && col >= 1 && col + 2 <= w && cp == hole_color) begin
          nb[0] = filled_pix[s][back_slot(c, h + 1)];
          nb[1] = filled_pix[s][back_slot(c, h)];
          nb[2] = filled_pix[s][back_slot(c, h - 1)];
          nb[3] = filled_pix[s][back_slot(c, 1)];
          nb[4] = arrived_pix[s][(c + 1) % HIST];
          nb[5] = arrived_pix[s][(c + h - 1) % HIST];
          nb[6] = arrived_pix[s][(c + h) % HIST];
          nb[7] = arrived_pix[s][(c + h + 1) % HIST];
          res = mean_of_eight(nb);
        end
        if (s == PASSES - 1) lst = (row + 1 == h) && (col + 1 == w);
        if (row + 1 >= h) begin
          row_at[s] = 0;
          col_at[s] = (col + 1 >= w) ? 0 : col + 1;
        end else begin
          row_at[s] = row + 1;
        end
      end
      filled_pix[s][c] = res;
      p = res;
      v = cv;
    end
    slot_wr = (wp + 1) % HIST;
    slot_count++;
    got = v;
    res_pix = p;
    res_last = lst;
  endtask

  function automatic int sender_gap();
    int r;
    if (send_calm > 0) begin
      send_calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 5) begin
      send_calm = $urandom_range(30, 150);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic pixel_t scene_pixel();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return hole_color;
    if (r < 50) return hole_color ^ (pixel_t'(1) << $urandom_range(0, PIX_W - 1));
    if (r < 60) return ($urandom_range(0, 1) != 0) ? 24'hFFFFFF : 24'h000000;
    return pixel_t'($urandom);
  endfunction

  task automatic send_word(input pixel_t pix, input logic fl, input logic typed,
                           input pixel_t tpix, input logic tlast);
    int gap;
    logic got;
    pixel_t rp;
    logic rl;
    known_word_t k;
    out_word_t e;
    gap = sender_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    pixel_in <= pix;
    flush <= fl;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
    if (!fl) begin
      k.typed = typed;
      k.pix = tpix;
      k.last = tlast;
      known_q = {known_q, k};
    end
    fill_chain_step(pix, fl, got, rp, rl);
    if (got) begin
      k = known_q.pop_front();
      e.pix = k.typed ? k.pix : rp;
      e.last = k.typed ? k.last : rl;
      filled_q = {filled_q, e};
    end
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    fill_cfg_write(idx, data);
  endtask

  task automatic drain_chain();
    repeat (PASSES * (eff_height() + 1)) send_word(pixel_t'($urandom), 1'b1, 1'b0, '0, 1'b0);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (filled_q.size() != 0) @(posedge clk);
    repeat (CHAIN_CYCLES) @(posedge clk);
  endtask

  // stimulus
  initial begin
    int phase, count, fr, h_raw, w_raw;
    logic [CFG_DATA_W-1:0] word;
    rst <= 1'b1;
    in_valid <= 1'b0;
    pixel_in <= '0;
    flush <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    fill_chain_reset();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    write_reg(REG_IMAGE_WIDTH, 24'd5);
    write_reg(REG_IMAGE_HEIGHT, 24'd3);
    cfg_valid <= 1'b0;
    for (int i = 0; i < N_CASES; i++)
      send_word(FILL_CASES[i].pix, FILL_CASES[i].fl, FILL_CASES[i].typed,
                FILL_CASES[i].exp_pix, FILL_CASES[i].exp_last);
    drain_chain();
    settle();

    phase = 1;
    while (words_sent < WORD_BUDGET) begin
      case (phase % 6)
        1: begin
          w_raw = $urandom_range(0, 2);
          h_raw = $urandom_range(0, 2);
        end
        3: begin
          w_raw = $urandom_range(1024, 2047);
          h_raw = $urandom_range(3, 5);
        end
        4: begin
          w_raw = $urandom_range(3, 4);
          h_raw = $urandom_range(9, 24);
        end
        default: begin
          w_raw = $urandom_range(3, 8);
          h_raw = $urandom_range(3, 8);
        end
      endcase
      // history must be fully written before the height moves
      if (slot_count < HIST + 8) h_raw = int'(rows_reg);
      word = CFG_DATA_W'($urandom);
      word[IMAGE_WIDTH_W-1:0] = IMAGE_WIDTH_W'(w_raw);
      write_reg(REG_IMAGE_WIDTH, word);
      word = CFG_DATA_W'($urandom);
      word[IMAGE_HEIGHT_W-1:0] = IMAGE_HEIGHT_W'(h_raw);
      write_reg(REG_IMAGE_HEIGHT, word);
      case ($urandom_range(0, 4))
        0: word = '0;
        1: word = 24'hFFFFFF;
        2: word = RESET_GAP_COLOR;
        default: word = CFG_DATA_W'($urandom);
      endcase
      write_reg(REG_GAP_COLOR, word);
      if (phase == 1 || $urandom_range(0, 2) == 0)
        write_reg(REG_UNMAPPED, CFG_DATA_W'($urandom));
      cfg_valid <= 1'b0;

      fr = eff_width() * eff_height();
      if (phase == 1) count = $urandom_range(150, 200);
      else if (eff_height() >= 9) count = $urandom_range(40, 90);
      else if (eff_width() >= 1000) count = $urandom_range(30, 80);
      else count = fr * $urandom_range(1, 4) + $urandom_range(0, fr - 1);

      for (int i = 0; i < count; i++) begin
        if ($urandom_range(0, 99) < 4) send_word(pixel_t'($urandom), 1'b1, 1'b0, '0, 1'b0);
        send_word(scene_pixel(), 1'b0, 1'b0, '0, 1'b0);
      end
      drain_chain();
      settle();
      phase++;
    end

    if (mismatches == 0)
      $display("** iterative_gap_fill_average_core: PASSED **");
    else
      $display("** iterative_gap_fill_average_core: FAILED **");
    $finish;
  end

  // receiver
  initial begin
    int r, stall_left, calm_left, hold_left;
    bit held;
    out_word_t e;
    out_ready <= 1'b0;
    stall_left = 0;
    calm_left = 0;
    hold_left = 0;
    held = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        if (filled_q.size() == 0) begin
          $error("unexpected word: pixel_out %h frame_last %b", pixel_out, frame_last);
          mismatches++;
        end else begin
          e = filled_q.pop_front();
          if (pixel_out !== e.pix) begin
            $error("pixel_out: expected %h, got %h", e.pix, pixel_out);
            mismatches++;
          end
          if (frame_last !== e.last) begin
            $error("frame_last: expected %b, got %b", e.last, frame_last);
            mismatches++;
          end
        end
        seen++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!held && seen >= 150) begin
        held = 1;
        hold_left = HOLD_CYCLES;
        out_ready <= 1'b0;
      end else if (calm_left > 0) begin
        calm_left--;
        out_ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 4) calm_left = $urandom_range(30, 150);
        else if (r < 20) stall_left = $urandom_range(1, 3);
        else if (r < 23) stall_left = $urandom_range(15, 50);
        out_ready <= (stall_left == 0);
      end
    end
  end

  // watchdog
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
          (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("** iterative_gap_fill_average_core: FAILED **");
    $finish;
  end

endmodule

### files.f
hdl/igfa_pkg.sv
hdl/igfa_ram.sv
hdl/igfa_cell.sv
hdl/iterative_gap_fill_average_core.sv
tb/iterative_gap_fill_average_core_tb.sv
